@@ rtl/core/lmts_pkg.sv @@
// Package with shared types and timing constants for the LCD mode timing sequencer.
`default_nettype none

package lmts_pkg;

	typedef enum logic [1:0] {
		MODE_HBLANK = 2'd0,
		MODE_VBLANK = 2'd1,
		MODE_OAM    = 2'd2,
		MODE_DRAW   = 2'd3
	} mode_t;

	localparam logic [15:0] OAM_CYCLES    = 16'd80;
	localparam logic [15:0] DRAW_CYCLES   = 16'd172;
	localparam logic [15:0] HBLANK_CYCLES = 16'd204;
	localparam logic [15:0] VLINE_CYCLES  = 16'd456;
	localparam logic [15:0] ACC_MAX       = 16'hFFFF;

	localparam logic [7:0] FIRST_VBLANK_LINE = 8'd144;
	localparam logic [7:0] LAST_LINE         = 8'd153;

	// Bit positions inside stat_enables.
	localparam int unsigned EN_HBLANK = 0;
	localparam int unsigned EN_VBLANK = 1;
	localparam int unsigned EN_OAM    = 2;
	localparam int unsigned EN_COINC  = 3;

	typedef struct packed {
		logic [7:0] cycles;
		logic       lcd_on;
		logic [7:0] line_compare;
		logic [3:0] stat_enables;
	} item_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] line;
		logic       coincidence;
		logic       vblank_irq;
		logic       stat_irq;
		logic       line_done;
	} result_t;

	typedef struct packed {
		logic [15:0] acc;
		mode_t       mode;
		logic [7:0]  line;
		logic        was_on;
	} state_t;

endpackage

`default_nettype wire

@@ rtl/core/lmts_chan_if.sv @@
// Valid/ready channel interface carrying one payload per transaction.
`default_nettype none

interface lmts_chan_if #(
	parameter type data_t = logic
);
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/lcd_mode_timing_sequencer.sv @@
// Top level of the LCD mode timing sequencer: input stage, step logic and result register.
// An accepted transaction is held in the input stage and then registered into the result
// register, from which it can be taken through the result channel.
// Throughput: one transaction per clock unless the result channel stalls; the state loop is
// one add, a few constant compares and a subtract through lmts_step between registers.
// Input and result stages each hold one item, so one more item is taken while a result waits.
// Reset (arst_n low, asynchronous): channels empty, accumulator and line zero,
// mode HBlank, LCD treated as previously off.
`default_nettype none

module lcd_mode_timing_sequencer (
	input wire logic    clk,
	input wire logic    arst_n,
	lmts_chan_if.sink   item,
	lmts_chan_if.source result
);
	import lmts_pkg::*;

	// Input stage.
	logic    valid_s1;
	item_t   item_s1;

	// Architectural state and result register.
	state_t  state_q;
	logic    res_valid_q;
	result_t res_q;

	state_t  state_nxt;
	result_t res_nxt;
	logic    advance;

	// Advance the input stage whenever the result register is free or being drained.
	assign advance     = !res_valid_q || result.ready;
	assign item.ready  = !valid_s1 || advance;
	assign result.valid = res_valid_q;
	assign result.data  = res_q;

	lmts_step u_step (
		.cur (state_q),
		.itm (item_s1),
		.nxt (state_nxt),
		.res (res_nxt)
	);

	// Capture incoming transactions.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid)
			item_s1 <= item.data;
	end

	// Commit state and load the result in the same edge, once per item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			state_q     <= '{acc: '0, mode: MODE_HBLANK, line: '0, was_on: 1'b0};
		end else if (advance) begin
			res_valid_q <= valid_s1;
			if (valid_s1)
				state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1)
			res_q <= res_nxt;
	end

	// Line never leaves the frame range.
	a_line_range : assert property (@(posedge clk) disable iff (!arst_n)
		state_q.line <= LAST_LINE)
		else $error("line counter beyond last line");

	// A VBlank request only comes with entry into VBlank on the first VBlank line.
	a_vblank_entry : assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.vblank_irq |->
		res_q.mode == MODE_VBLANK && res_q.line == FIRST_VBLANK_LINE)
		else $error("vblank request outside vblank entry");

	// End of drawing always lands in HBlank.
	a_done_hblank : assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.line_done |-> res_q.mode == MODE_HBLANK)
		else $error("line done without hblank");

	// With the LCD off the sequencer sits idle at line 0.
	a_off_idle : assert property (@(posedge clk) disable iff (!arst_n)
		!state_q.was_on |-> state_q.acc == '0 && state_q.line == '0 &&
		state_q.mode == MODE_HBLANK)
		else $error("state not idle while lcd off");

	// A committed item drops the stage result into the output register.
	a_commit : assert property (@(posedge clk) disable iff (!arst_n)
		advance && valid_s1 |=> res_valid_q && state_q.line == res_q.line)
		else $error("result and state out of step");

endmodule

`default_nettype wire

@@ rtl/core/lmts_step.sv @@
// Next-state and result logic for one batch of elapsed cycles.
`default_nettype none

module lmts_step (
	input  lmts_pkg::state_t  cur,
	input  lmts_pkg::item_t   itm,
	output lmts_pkg::state_t  nxt,
	output lmts_pkg::result_t res
);
	import lmts_pkg::*;

	state_t      base;
	logic [16:0] sum;
	logic [15:0] acc_sat;
	logic [7:0]  line_inc;
	logic        stat;
	logic        vbl;
	logic        done;
	logic        coinc_en;

	assign coinc_en = itm.stat_enables[EN_COINC];
	assign sum      = {1'b0, base.acc} + {9'd0, itm.cycles};
	assign acc_sat  = sum[16] ? ACC_MAX : sum[15:0];
	assign line_inc = base.line + 8'd1;

	always_comb begin
		// Restart on a rising LCD enable.
		base = cur;
		stat = 1'b0;
		vbl  = 1'b0;
		done = 1'b0;
		if (itm.lcd_on && !cur.was_on) begin
			base.acc  = '0;
			base.mode = MODE_OAM;
			base.line = '0;
			if (itm.stat_enables[EN_OAM])
				stat = 1'b1;
			if (coinc_en && itm.line_compare == 8'd0)
				stat = 1'b1;
		end
		nxt        = base;
		nxt.was_on = itm.lcd_on;
		if (!itm.lcd_on) begin
			nxt.acc  = '0;
			nxt.mode = MODE_HBLANK;
			nxt.line = '0;
			stat     = 1'b0;
		end else begin
			nxt.acc = acc_sat;
			unique case (base.mode)
				MODE_OAM: begin
					if (acc_sat >= OAM_CYCLES) begin
						nxt.acc  = acc_sat - OAM_CYCLES;
						nxt.mode = MODE_DRAW;
					end
				end
				MODE_DRAW: begin
					if (acc_sat >= DRAW_CYCLES) begin
						nxt.acc  = acc_sat - DRAW_CYCLES;
						nxt.mode = MODE_HBLANK;
						done     = 1'b1;
						if (itm.stat_enables[EN_HBLANK])
							stat = 1'b1;
					end
				end
				MODE_HBLANK: begin
					if (acc_sat >= HBLANK_CYCLES) begin
						nxt.acc  = acc_sat - HBLANK_CYCLES;
						nxt.line = line_inc;
						if (coinc_en && line_inc == itm.line_compare)
							stat = 1'b1;
						if (line_inc >= FIRST_VBLANK_LINE) begin
							nxt.mode = MODE_VBLANK;
							vbl      = 1'b1;
							if (itm.stat_enables[EN_VBLANK])
								stat = 1'b1;
						end else begin
							nxt.mode = MODE_OAM;
							if (itm.stat_enables[EN_OAM])
								stat = 1'b1;
						end
					end
				end
				MODE_VBLANK: begin
					if (acc_sat >= VLINE_CYCLES) begin
						nxt.acc = acc_sat - VLINE_CYCLES;
						if (base.line >= LAST_LINE) begin
							nxt.line = '0;
							nxt.mode = MODE_OAM;
							if (itm.stat_enables[EN_OAM])
								stat = 1'b1;
						end else begin
							nxt.line = line_inc;
						end
						if (coinc_en && nxt.line == itm.line_compare)
							stat = 1'b1;
					end
				end
				default: begin
					nxt = base;
				end
			endcase
		end
		res.mode        = nxt.mode;
		res.line        = nxt.line;
		res.coincidence = (nxt.line == itm.line_compare);
		res.vblank_irq  = vbl;
		res.stat_irq    = stat;
		res.line_done   = done;
	end

endmodule

`default_nettype wire
